// ===== hdl/force_torque_frame_decoder_assert.svh =====
// Assertion macros used by the force/torque frame decoder back end module.
`ifndef FORCE_TORQUE_FRAME_DECODER_ASSERT_SVH
`define FORCE_TORQUE_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FTFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define FTFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ftfd_pkg.sv =====
// Shared types, constants and helpers of the force/torque frame decoder.
package ftfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int READING_W  = 16;
  localparam int NUM_AXES   = 6;
  localparam int AXIS_IDX_W = $clog2(NUM_AXES);
  localparam int AXIS_FZ    = 2;
  localparam int Q8_W       = 19;
  localparam int GAIN_W     = 16;
  localparam int CFG_CAL_W  = 13;
  localparam int OFS_W      = 20;
  localparam int PROD_W     = READING_W + GAIN_W + 1;
  localparam int FRAME_W    = NUM_AXES * READING_W;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Frame header bytes
  localparam logic [BYTE_W-1:0] HDR_B0 = 8'd170;
  localparam logic [BYTE_W-1:0] HDR_B1 = 8'd7;
  localparam logic [BYTE_W-1:0] HDR_B2 = 8'd8;
  localparam logic [BYTE_W-1:0] HDR_B3 = 8'd16;

  // Payload byte window holding the six readings
  localparam int RD_FIRST = 4;
  localparam int RD_LAST  = 15;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(128);
  localparam logic signed [31:0] Q8_MAX = 32'sd262143;
  localparam logic signed [31:0] Q8_MIN = -32'sd262144;

  // Register map
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_FT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_FZ     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd2;

  localparam logic [GAIN_W-1:0]    GAIN_FT_RST     = 16'd1612;
  localparam logic [GAIN_W-1:0]    GAIN_FZ_RST     = 16'd784;
  localparam logic [CFG_CAL_W-1:0] CAL_SAMPLES_RST = 13'd500;

  typedef logic signed [Q8_W-1:0] q8_t;
  typedef logic [NUM_AXES-1:0][READING_W-1:0] frame_t;

  typedef enum logic [2:0] {
    HUNT_B0, HUNT_B1, HUNT_B2, HUNT_B3, HUNT_PAYLOAD
  } hunt_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_RND, BK_CAL, BK_DIV, BK_ZERO, BK_OUT
  } back_t;

  typedef struct packed {
    q8_t  force_x;
    q8_t  force_y;
    q8_t  force_z;
    q8_t  torque_x;
    q8_t  torque_y;
    q8_t  torque_z;
    q8_t  zeroed_fz;
    logic calibrated;
  } result_t;

  function automatic q8_t sat_q8(input logic signed [31:0] v);
    q8_t r;
    if (v > Q8_MAX) begin
      r = Q8_MAX[Q8_W-1:0];
    end else if (v < Q8_MIN) begin
      r = Q8_MIN[Q8_W-1:0];
    end else begin
      r = v[Q8_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ftfd_fifo.sv =====
// Two-entry queue used between the decoder stages and at the result side.
module ftfd_fifo import ftfd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   fill;
  logic do_push;
  logic do_pop;

  assign full    = (fill == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

// ===== hdl/ftfd_front.sv =====
// Byte-level front end: header hunt and collection of the six readings.
module ftfd_front import ftfd_pkg::*; #(
  parameter int PAYLOAD_BYTES = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              full,
  output logic              fq_push,
  output frame_t            fq_data,
  input  logic              fq_full
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  hunt_t state;
  hunt_t state_next;
  logic [CNT_W-1:0]   count;
  logic [FRAME_W-1:0] readings;
  logic accept;
  logic in_window;
  logic frame_end;

  assign full      = fq_full;
  assign accept    = push & ~fq_full;
  assign in_window = (count >= CNT_W'(RD_FIRST)) && (count <= CNT_W'(RD_LAST));
  assign frame_end = (state == HUNT_PAYLOAD) && (count == CNT_LAST);

  always_comb begin
    state_next = state;
    if (accept) begin
      case (state)
        HUNT_B1: begin
          state_next = (rx_byte == HDR_B1) ? HUNT_B2 :
                       (rx_byte == HDR_B0) ? HUNT_B1 : HUNT_B0;
        end
        HUNT_B2: begin
          state_next = (rx_byte == HDR_B2) ? HUNT_B3 :
                       (rx_byte == HDR_B0) ? HUNT_B1 : HUNT_B0;
        end
        HUNT_B3: begin
          state_next = (rx_byte == HDR_B3) ? HUNT_PAYLOAD :
                       (rx_byte == HDR_B0) ? HUNT_B1 : HUNT_B0;
        end
        HUNT_PAYLOAD: begin
          state_next = frame_end ? HUNT_B0 : HUNT_PAYLOAD;
        end
        default: begin
          state_next = (rx_byte == HDR_B0) ? HUNT_B1 : HUNT_B0;
        end
      endcase
    end
  end

  // A frame leaves with its last byte; that byte joins it if it is a reading byte.
  always_comb begin
    fq_push = accept && frame_end;
    fq_data = in_window ? {readings[FRAME_W-BYTE_W-1:0], rx_byte} : readings;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT_B0;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && (state == HUNT_PAYLOAD)) begin
        count <= frame_end ? '0 : count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (state == HUNT_PAYLOAD) && in_window) begin
      readings <= {readings[FRAME_W-BYTE_W-1:0], rx_byte};
    end
  end

endmodule

// ===== hdl/ftfd_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ftfd_div import ftfd_pkg::*; #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              running;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(NUM_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (running) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/ftfd_back.sv =====
// Frame back end: gain scaling, fz zero calibration and result assembly.
`include "force_torque_frame_decoder_assert.svh"

module ftfd_back import ftfd_pkg::*; #(
  parameter int MAX_CAL_SAMPLES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fq_empty,
  input  frame_t               fq_data,
  output logic                 fq_pop,
  input  logic [GAIN_W-1:0]    gain_ft,
  input  logic [GAIN_W-1:0]    gain_fz,
  input  logic [CFG_CAL_W-1:0] cal_samples,
  input  logic                 res_full,
  output logic                 res_push,
  output result_t              res_data
);

  localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int TGT_W = (CNT_W > CFG_CAL_W) ? CNT_W : CFG_CAL_W;
  localparam int ACC_W = Q8_W + CNT_W;

  back_t state;
  back_t state_next;

  frame_t                   frame_q;
  logic [AXIS_IDX_W-1:0]    k;
  logic [AXIS_IDX_W-1:0]    sel;
  logic [GAIN_W-1:0]        gain_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [PROD_W-1:0] rnd_shift;
  q8_t                      vals [NUM_AXES];
  q8_t                      zfz;
  logic                     cal;

  logic signed [ACC_W-1:0]  fz_accumulator;
  logic [CNT_W-1:0]         samples_taken;
  logic signed [OFS_W-1:0]  fz_offset;
  logic [TGT_W-1:0]         target;
  logic                     below_target;
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W-1:0]         quot;
  logic [ACC_W-1:0]         ofs_full;
  logic                     div_start;
  logic                     div_done;

  assign sel       = AXIS_IDX_W'(NUM_AXES - 1) - k;
  assign gain_sel  = (k == AXIS_IDX_W'(AXIS_FZ)) ? gain_fz : gain_ft;
  assign rnd_sum   = prod + ROUND_HALF;
  assign rnd_shift = rnd_sum >>> 8;

  // Zero target clamped to 1..MAX_CAL_SAMPLES
  always_comb begin
    if (cal_samples == '0) begin
      target = TGT_W'(1);
    end else if (TGT_W'(cal_samples) > TGT_W'(MAX_CAL_SAMPLES)) begin
      target = TGT_W'(MAX_CAL_SAMPLES);
    end else begin
      target = TGT_W'(cal_samples);
    end
  end

  assign below_target = (TGT_W'(samples_taken) < target);
  assign acc_mag  = fz_accumulator[ACC_W-1] ? ACC_W'(-fz_accumulator) : fz_accumulator;
  assign ofs_full = fz_accumulator[ACC_W-1] ? ACC_W'(-quot) : quot;

  ftfd_div #(
    .NUM_W (ACC_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc_mag),
    .den   (samples_taken),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!fq_empty) state_next = BK_MUL;
      BK_MUL:  state_next = BK_RND;
      BK_RND:  state_next = (k == AXIS_IDX_W'(NUM_AXES - 1)) ? BK_CAL : BK_MUL;
      BK_CAL:  state_next = below_target ? BK_OUT : BK_DIV;
      BK_DIV:  if (div_done) state_next = BK_ZERO;
      BK_ZERO: state_next = BK_OUT;
      BK_OUT:  if (!res_full) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    fq_pop    = (state == BK_IDLE) && !fq_empty;
    res_push  = (state == BK_OUT) && !res_full;
    div_start = (state == BK_CAL) && !below_target;
  end

  always_comb begin
    res_data.force_x    = vals[0];
    res_data.force_y    = vals[1];
    res_data.force_z    = vals[2];
    res_data.torque_x   = vals[3];
    res_data.torque_y   = vals[4];
    res_data.torque_z   = vals[5];
    res_data.zeroed_fz  = zfz;
    res_data.calibrated = cal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_IDLE;
      k              <= '0;
      fz_accumulator <= '0;
      samples_taken  <= '0;
      fz_offset      <= '0;
    end else begin
      state <= state_next;
      case (state)
        BK_IDLE: k <= '0;
        BK_RND:  k <= k + 1'b1;
        BK_CAL: begin
          if (below_target) begin
            fz_accumulator <= fz_accumulator +
                              {{(ACC_W - Q8_W){vals[AXIS_FZ][Q8_W-1]}}, vals[AXIS_FZ]};
            samples_taken  <= samples_taken + 1'b1;
          end
        end
        BK_DIV: if (div_done) fz_offset <= ofs_full[OFS_W-1:0];
        default: k <= k;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (!fq_empty) frame_q <= fq_data;
      BK_MUL:  prod <= $signed(frame_q[sel]) * $signed({1'b0, gain_sel});
      BK_RND:  vals[k] <= sat_q8(rnd_shift[31:0]);
      BK_CAL: begin
        if (below_target) begin
          zfz <= '0;
          cal <= 1'b0;
        end
      end
      BK_ZERO: begin
        zfz <= sat_q8(32'(fz_offset) - 32'(vals[AXIS_FZ]));
        cal <= 1'b1;
      end
      default: cal <= cal;
    endcase
  end

  `FTFD_ASSERT_NXT(a_div_to_zero, (state == BK_DIV) && div_done, state == BK_ZERO, "divide result not applied")
  `FTFD_ASSERT_IMP(a_uncal_zero, res_push && !res_data.calibrated, res_data.zeroed_fz == '0, "zeroed_fz set before calibration")
  `FTFD_ASSERT_IMP(a_samples_max, state == BK_CAL, samples_taken <= CNT_W'(MAX_CAL_SAMPLES), "sample count beyond limit")
  `FTFD_ASSERT_NXT(a_sample_step, (state == BK_CAL) && below_target, samples_taken == $past(samples_taken) + 1'b1, "sample count not advanced")

endmodule

// ===== hdl/force_torque_frame_decoder.sv =====
// Top level of the force/torque frame decoder: register file and stage wiring.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------
//  bytes    | in        | push / full          | rx_byte
//  results  | out       | pop / empty          | force_x..torque_z, zeroed_fz, calibrated
//  config   | in        | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// The front end takes one byte per cycle; full mirrors the two-entry frame
// queue, so every byte is held off while both entries are taken.
// Back end per frame: a pop, six multiply/round passes on one shared
// multiplier, a calibration step and an output step; once calibrated, a
// bit-serial divide of the ACC_W-bit fz sum and a zeroing step follow
// (ACC_W = 19 + clog2(MAX_CAL_SAMPLES + 1), 32 by default). A frame is PAYLOAD_BYTES
// + 4 bytes; the back end keeps pace while calibrating, but the divide can make it lag.
// Reset (rst, synchronous) clears hunt, queues, calibration sums and registers;
// there is no clearing pass. Results wait in a two-entry output queue while pop is low.
module force_torque_frame_decoder import ftfd_pkg::*; #(
  parameter int PAYLOAD_BYTES   = 18,
  parameter int MAX_CAL_SAMPLES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // byte stream
  input  logic              push,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              full,
  // results
  output logic              empty,
  input  logic              pop,
  output logic [Q8_W-1:0]   force_x,
  output logic [Q8_W-1:0]   force_y,
  output logic [Q8_W-1:0]   force_z,
  output logic [Q8_W-1:0]   torque_x,
  output logic [Q8_W-1:0]   torque_y,
  output logic [Q8_W-1:0]   torque_z,
  output logic [Q8_W-1:0]   zeroed_fz,
  output logic              calibrated,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Registers
  logic [GAIN_W-1:0]    gain_force_torque;
  logic [GAIN_W-1:0]    gain_vertical_force;
  logic [CFG_CAL_W-1:0] calibration_samples;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  // Stage links
  logic    fq_push;
  logic    fq_full;
  logic    fq_pop;
  logic    fq_empty;
  frame_t  fq_wdata;
  frame_t  fq_rdata;
  logic    res_push;
  logic    res_full;
  result_t res_wdata;
  result_t res_rdata;

  // APB: word-aligned registers, writes land on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_force_torque   <= GAIN_FT_RST;
      gain_vertical_force <= GAIN_FZ_RST;
      calibration_samples <= CAL_SAMPLES_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_GAIN_FT:     gain_force_torque   <= pwdata[GAIN_W-1:0];
        REG_GAIN_FZ:     gain_vertical_force <= pwdata[GAIN_W-1:0];
        REG_CAL_SAMPLES: calibration_samples <= pwdata[CFG_CAL_W-1:0];
        default:         gain_force_torque   <= gain_force_torque;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_FT:     prdata = 32'(gain_force_torque);
      REG_GAIN_FZ:     prdata = 32'(gain_vertical_force);
      REG_CAL_SAMPLES: prdata = 32'(calibration_samples);
      default:         prdata = '0;
    endcase
  end

  // Front end: header hunt and reading capture
  ftfd_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .fq_push (fq_push),
    .fq_data (fq_wdata),
    .fq_full (fq_full)
  );

  // Frames waiting for the back end
  ftfd_fifo #(
    .WIDTH ($bits(frame_t))
  ) u_frame_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Back end: scaling and fz zeroing
  ftfd_back #(
    .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fq_empty    (fq_empty),
    .fq_data     (fq_rdata),
    .fq_pop      (fq_pop),
    .gain_ft     (gain_force_torque),
    .gain_fz     (gain_vertical_force),
    .cal_samples (calibration_samples),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_wdata)
  );

  // Finished items wait here for pop
  ftfd_fifo #(
    .WIDTH ($bits(result_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign force_x    = res_rdata.force_x;
  assign force_y    = res_rdata.force_y;
  assign force_z    = res_rdata.force_z;
  assign torque_x   = res_rdata.torque_x;
  assign torque_y   = res_rdata.torque_y;
  assign torque_z   = res_rdata.torque_z;
  assign zeroed_fz  = res_rdata.zeroed_fz;
  assign calibrated = res_rdata.calibrated;

endmodule

// ===== tb/force_torque_frame_decoder_tb.sv =====
// Self-checking bench for the force/torque frame decoder: byte stream in, scaled wrenches out.
module force_torque_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ftfd_pkg::*;

  localparam int     PAYLOAD_LEN  = 18;
  localparam int     CAL_CEILING  = 4096;
  localparam int     DRAIN_CYCLES = 80;   // back end plus bit-serial divide, with margin
  localparam longint Q8_ROUND     = 128;  // half an LSB before dropping 8 fraction bits

  // Index past the end of the register map; writes there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Predicts one wrench per completed frame and checks the block's results in order.
  class wrench_scoreboard;
    logic [GAIN_W-1:0]    gain_ft;
    logic [GAIN_W-1:0]    gain_fz;
    logic [CFG_CAL_W-1:0] cal_target;
    hunt_t                hunt;
    int unsigned          body_len;
    logic [BYTE_W-1:0]    body [PAYLOAD_LEN];
    longint               fz_sum;
    longint               fz_ofs;
    int unsigned          fz_count;
    result_t              pending_wrenches [$];
    int unsigned          faults;

    function new();
      gain_ft    = GAIN_FT_RST;
      gain_fz    = GAIN_FZ_RST;
      cal_target = CAL_SAMPLES_RST;
      hunt       = HUNT_B0;
      body_len   = 0;
      fz_sum     = 0;
      fz_ofs     = 0;
      fz_count   = 0;
      faults     = 0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_GAIN_FT:     gain_ft    = value[GAIN_W-1:0];
        REG_GAIN_FZ:     gain_fz    = value[GAIN_W-1:0];
        REG_CAL_SAMPLES: cal_target = value[CFG_CAL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip_q8(longint v);
      if (v > longint'(Q8_MAX)) return longint'(Q8_MAX);
      if (v < longint'(Q8_MIN)) return longint'(Q8_MIN);
      return v;
    endfunction

    // Q16 gain times signed count, rounded to Q8 with floor, then clipped.
    function longint scale_axis(logic [READING_W-1:0] raw, logic [GAIN_W-1:0] gain);
      longint t;
      t = longint'(shortint'(raw)) * longint'(gain) + Q8_ROUND;
      return clip_q8(t >>> 8);
    endfunction

    function void close_frame();
      longint      v [NUM_AXES];
      longint      zfz;
      logic        cal;
      int unsigned tgt;
      result_t     w;
      for (int k = 0; k < NUM_AXES; k++) begin
        v[k] = scale_axis({body[RD_FIRST + 2*k], body[RD_FIRST + 2*k + 1]},
                          (k == AXIS_FZ) ? gain_fz : gain_ft);
      end
      tgt = cal_target;
      if (tgt < 1) tgt = 1;
      if (tgt > CAL_CEILING) tgt = CAL_CEILING;
      if (fz_count < tgt) begin
        fz_sum += v[AXIS_FZ];
        fz_count++;
        zfz = 0;
        cal = 1'b0;
      end else begin
        fz_ofs = fz_sum / longint'(fz_count);
        zfz    = clip_q8(fz_ofs - v[AXIS_FZ]);
        cal    = 1'b1;
      end
      w.force_x    = q8_t'(v[0]);
      w.force_y    = q8_t'(v[1]);
      w.force_z    = q8_t'(v[2]);
      w.torque_x   = q8_t'(v[3]);
      w.torque_y   = q8_t'(v[4]);
      w.torque_z   = q8_t'(v[5]);
      w.zeroed_fz  = q8_t'(zfz);
      w.calibrated = cal;
      pending_wrenches = {pending_wrenches, w};
    endfunction

    // A mismatching header byte is looked at again as a possible first byte.
    function void take_byte(logic [BYTE_W-1:0] b);
      case (hunt)
        HUNT_B1: hunt = (b == HDR_B1) ? HUNT_B2 : (b == HDR_B0) ? HUNT_B1 : HUNT_B0;
        HUNT_B2: hunt = (b == HDR_B2) ? HUNT_B3 : (b == HDR_B0) ? HUNT_B1 : HUNT_B0;
        HUNT_B3: begin
          if (b == HDR_B3) begin
            hunt     = HUNT_PAYLOAD;
            body_len = 0;
          end else begin
            hunt = (b == HDR_B0) ? HUNT_B1 : HUNT_B0;
          end
        end
        HUNT_PAYLOAD: begin
          body[body_len] = b;
          body_len++;
          if (body_len == PAYLOAD_LEN) begin
            hunt     = HUNT_B0;
            body_len = 0;
            close_frame();
          end
        end
        default: hunt = (b == HDR_B0) ? HUNT_B1 : HUNT_B0;
      endcase
    endfunction

    task report(string msg);
      if (faults < 100) $display("MISMATCH @%0t: %s", $time, msg);
      faults++;
    endtask

    task match_field(string label, q8_t got, q8_t want);
      if (got !== want) report($sformatf("%s got %0d want %0d", label, got, want));
    endtask

    task check_wrench(result_t got);
      result_t want;
      if (pending_wrenches.size() == 0) begin
        report("result with nothing outstanding");
      end else begin
        want = pending_wrenches.pop_front();
        match_field("force_x", got.force_x, want.force_x);
        match_field("force_y", got.force_y, want.force_y);
        match_field("force_z", got.force_z, want.force_z);
        match_field("torque_x", got.torque_x, want.torque_x);
        match_field("torque_y", got.torque_y, want.torque_y);
        match_field("torque_z", got.torque_z, want.torque_z);
        match_field("zeroed_fz", got.zeroed_fz, want.zeroed_fz);
        match_field("calibrated", q8_t'(got.calibrated), q8_t'(want.calibrated));
      end
    endtask
  endclass

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              pop     = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [3:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic              full;
  logic              empty;
  logic [Q8_W-1:0]   force_x;
  logic [Q8_W-1:0]   force_y;
  logic [Q8_W-1:0]   force_z;
  logic [Q8_W-1:0]   torque_x;
  logic [Q8_W-1:0]   torque_y;
  logic [Q8_W-1:0]   torque_z;
  logic [Q8_W-1:0]   zeroed_fz;
  logic              calibrated;
  logic [31:0]       prdata;
  logic              pready;

  wrench_scoreboard sb = new();
  int unsigned      sent         = 0;
  int unsigned      hold_request = 0;  // long receiver hold-off, taken up by the pop side

  // Opening frame: a second 170 after "170 7" must restart the header,
  // then readings at both ends of the 16-bit range, -1, 0 and 1.
  logic [BYTE_W-1:0] opening [24] = '{
    HDR_B0, HDR_B1, HDR_B0, HDR_B1, HDR_B2, HDR_B3,
    8'h00, 8'hFF, 8'h55, 8'hAA,
    8'h7F, 8'hFF, 8'h80, 8'h00, 8'h80, 8'h00,
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
    8'hFF, 8'h00
  };

  force_torque_frame_decoder #(
    .PAYLOAD_BYTES   (PAYLOAD_LEN),
    .MAX_CAL_SAMPLES (CAL_CEILING)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .force_x    (force_x),
    .force_y    (force_y),
    .force_z    (force_z),
    .torque_x   (torque_x),
    .torque_y   (torque_y),
    .torque_z   (torque_z),
    .zeroed_fz  (zeroed_fz),
    .calibrated (calibrated),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(int unsigned i);
    case (i)
      0:       return HDR_B0;
      1:       return HDR_B1;
      2:       return HDR_B2;
      default: return HDR_B3;
    endcase
  endfunction

  // Called at a rising edge. push stays high across back-to-back items so it
  // is never dropped and raised in the same step.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input int unsigned gap);
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    sb.take_byte(b);
    sent++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Well-formed frame with random content; readings lean towards the extremes.
  task automatic send_frame(input bit lead_dup, input bit steady);
    logic [BYTE_W-1:0]    frame_body [PAYLOAD_LEN];
    logic [READING_W-1:0] rd;
    int unsigned          pick;
    int unsigned          i;
    for (i = 0; i < PAYLOAD_LEN; i++) frame_body[i] = BYTE_W'($urandom);
    for (i = 0; i < NUM_AXES; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) rd = 16'h7FFF;
      else if (pick < 20) rd = 16'h8000;
      else if (pick < 25) rd = 16'h0000;
      else if (pick < 30) rd = 16'hFFFF;
      else rd = READING_W'($urandom);
      frame_body[RD_FIRST + 2*i]     = rd[15:8];
      frame_body[RD_FIRST + 2*i + 1] = rd[7:0];
    end
    if (lead_dup) send_byte(HDR_B0, pick_gap(steady));
    for (i = 0; i < 4; i++) send_byte(hdr_byte(i), pick_gap(steady));
    for (i = 0; i < PAYLOAD_LEN; i++) send_byte(frame_body[i], pick_gap(steady));
  endtask

  // Mix of good frames, frames behind a doubled 170, cut-off headers and line noise.
  task automatic run_traffic(input int unsigned budget);
    int unsigned first;
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    bit          steady;
    first = sent;
    while (sent - first < budget) begin
      kind   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 9) == 0);
      if (kind < 75) begin
        send_frame(1'b0, steady);
      end else if (kind < 80) begin
        send_frame(1'b1, steady);
      end else if (kind < 90) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) send_byte(hdr_byte(i), pick_gap(steady));
        send_byte($urandom_range(0, 1) ? HDR_B0 : BYTE_W'($urandom), pick_gap(steady));
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send_byte(BYTE_W'($urandom), pick_gap(steady));
      end
    end
  endtask

  // Drain: all outstanding wrenches back, then room for a frame still in flight.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending_wrenches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access; the write lands on the edge that ends the access.
  // The bus then goes idle before the task returns, so the next transfer starts from a quiet bus.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // Receiver: random pop with short and long hold-offs and some unbroken runs.
  initial begin
    result_t     got;
    int unsigned hold;
    int unsigned streak;
    int unsigned r;
    hold   = 0;
    streak = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.force_x    = force_x;
        got.force_y    = force_y;
        got.force_z    = force_z;
        got.torque_x   = torque_x;
        got.torque_y   = torque_y;
        got.torque_z   = torque_z;
        got.zeroed_fz  = zeroed_fz;
        got.calibrated = calibrated;
        sb.check_wrench(got);
      end
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
        streak       = 0;
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else if (streak != 0) begin
        pop <= 1'b1;
        streak--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          pop <= 1'b1;
        end else if (r < 70) begin
          pop    <= 1'b1;
          streak = $urandom_range(40, 160);
        end else if (r < 95) begin
          pop  <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          pop  <= 1'b0;
          hold = $urandom_range(20, 80);
        end
      end
    end
  end

  // Main sequence: each phase runs traffic under one register setting.
  initial begin
    int unsigned i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: target of 500 is never reached, so nothing is calibrated yet.
    for (i = 0; i < 24; i++) send_byte(opening[i], pick_gap(1'b0));
    run_traffic(200);
    settle();

    // Zero target acts as one: calibrated at once on the sum so far; full gains saturate.
    write_register(REG_CAL_SAMPLES, 32'd0);
    write_register(REG_GAIN_FT, {16'd0, {GAIN_W{1'b1}}});
    write_register(REG_GAIN_FZ, {16'd0, {GAIN_W{1'b1}}});
    run_traffic(250);
    settle();

    // Target raised past the count: accumulation resumes, with zero gains.
    // Top of range, then the widest value which is clamped; a stray index is ignored.
    write_register(REG_GAIN_FT, 32'd0);
    write_register(REG_GAIN_FZ, 32'd0);
    write_register(REG_CAL_SAMPLES, CAL_CEILING);
    write_register(REG_SPARE, 32'hFFFF_FFFF);
    write_register(REG_CAL_SAMPLES, {19'd0, {CFG_CAL_W{1'b1}}});
    run_traffic(200);
    settle();

    // Target of one, random gains; receiver holds off long enough to back up the input.
    write_register(REG_CAL_SAMPLES, 32'd1);
    write_register(REG_GAIN_FT, $urandom_range(0, 65535));
    write_register(REG_GAIN_FZ, $urandom_range(0, 65535));
    hold_request = 600;
    run_traffic(300);
    settle();

    // Target just ahead of the count, so calibration completes mid-phase.
    write_register(REG_CAL_SAMPLES, sb.fz_count + 6);
    write_register(REG_GAIN_FT, $urandom_range(0, 65535));
    write_register(REG_GAIN_FZ, $urandom_range(0, 4096));
    run_traffic(350);

    push <= 1'b0;
    while (sb.pending_wrenches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
